@@ rtl/packed_next_hop_table_macros.svh @@
// Assertion macros for the packed next-hop table.
// Included by the RTL files that carry assertions. Needs clk and rst in scope.
`ifndef PACKED_NEXT_HOP_TABLE_MACROS_SVH
`define PACKED_NEXT_HOP_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PNHT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PNHT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pnht_pkg.sv @@
// Shared types and constants for the packed next-hop table.
// No dependencies.
package pnht_pkg;

  localparam int MAX_NODES   = 256;
  localparam int PAIR_COUNT  = (MAX_NODES * (MAX_NODES - 1)) / 2;
  localparam int PAIR_AW     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  localparam int NODE_W      = 8;
  localparam int SLOT_FW     = 2 * NODE_W + 1;   // triangle index plus low node
  localparam int CFG_W       = 9;

  localparam int ROUTE_DEPTH = 256;
  localparam int RT_AW       = $clog2(ROUTE_DEPTH);
  localparam int RT_LW       = RT_AW + 1;

  localparam logic [7:0] CODE_UNSOLVED = 8'h80;
  localparam logic [7:0] CODE_NONE     = 8'hff;

  typedef enum logic [1:0] {
    F_LOOKUP = 2'd0,
    F_WRITE  = 2'd1,
    F_ROUTE  = 2'd2,
    F_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNSOLVED = 2'd1,
    ST_NONE     = 2'd2
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [1:0]        dir;
  } rt_entry_t;

endpackage

@@ rtl/packed_next_hop_table.sv @@
// Packed next-hop table: lower-triangular pair table, route buffer and stamper.
// Depends on pnht_pkg and packed_next_hop_table_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | func, from_node, to_node, step_dir,
//          |                      | mark_unreachable, route_last
//  out     | out_valid / out_ready| dir_out, status
//  cfg     | cfg_valid / cfg_ready| cfg_data (node_count)
//
// One item at a time; the result sits in an output register, so a new item is
// taken while the previous result waits. Lookup and write run a pair-table
// read-modify-write: slot, read, update, respond. A route step is buffered; a
// last one then stamps each buffered pair i < j: read, load, slot, read, update.
// Clear item and reset run a clearing pass over all PAIR_COUNT entries (32640 at
// 256 nodes), one per cycle, taking no item meanwhile. cfg_ready is always
// high; the user must write node_count only while idle, unchecked by the block.
`include "packed_next_hop_table_macros.svh"

module packed_next_hop_table
  import pnht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  // item in
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [1:0]        step_dir,
  input  logic              mark_unreachable,
  input  logic              route_last,
  // result out
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        dir_out,
  output logic [1:0]        status
);

  typedef enum logic [3:0] {
    S_CLR,    // clearing pass
    S_IDLE,
    S_SLOT,   // pair -> slot index
    S_TRD,    // table read in flight
    S_TUSE,   // table data back: answer or write
    S_ROUTE,  // buffer a route step
    S_PRD,    // route buffer read in flight
    S_PLD,    // route data back: load pair
    S_RESP
  } state_t;

  state_t state;

  // config
  logic [CFG_W-1:0] node_count;

  // item registers
  func_t             op;
  logic [NODE_W-1:0] a_reg, b_reg;
  logic [1:0]        dir_reg, opp_reg, prev_dir;
  logic              unr_reg, last_reg;
  logic [1:0]        res_dir;
  status_t           res_st;

  // pair table
  logic [7:0]         tbl_mem [PAIR_COUNT];
  logic [7:0]         tbl_rd;
  logic [PAIR_AW-1:0] tbl_raddr, tbl_waddr, clr_addr;
  logic [7:0]         tbl_wdata;
  logic               tbl_we;
  logic               swp, pv, clr_resp;

  // route buffer
  rt_entry_t        route_mem [ROUTE_DEPTH];
  rt_entry_t        rt_rd_a, rt_rd_b;
  logic             rt_we;
  logic [RT_LW-1:0] route_length, stamp_len, len_new;
  logic [RT_AW-1:0] si, sj;

  // slot calculation
  logic [NODE_W-1:0]    hi, lo;
  logic [2*NODE_W-1:0]  prod;
  logic [SLOT_FW-1:0]   slot_full;
  logic                 a_ok, b_ok, pair_ok;
  logic [1:0]           jm1_dir;
  logic [7:0]           base, wr_dir, stamp_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  // hi*(hi-1)/2 + lo
  assign hi        = (a_reg > b_reg) ? a_reg : b_reg;
  assign lo        = (a_reg > b_reg) ? b_reg : a_reg;
  assign prod      = (2*NODE_W)'(hi) * (2*NODE_W)'(hi - NODE_W'(1));
  assign slot_full = SLOT_FW'(prod >> 1) + SLOT_FW'(lo);
  assign a_ok      = ({1'b0, a_reg} < node_count) && (int'(a_reg) < MAX_NODES);
  assign b_ok      = ({1'b0, b_reg} < node_count) && (int'(b_reg) < MAX_NODES);
  assign pair_ok   = (a_reg != b_reg) && a_ok && b_ok && (int'(slot_full) < PAIR_COUNT);

  assign len_new   = (route_length < RT_LW'(ROUTE_DEPTH)) ? route_length + RT_LW'(1)
                                                           : route_length;
  assign jm1_dir   = (sj == si + RT_AW'(1)) ? rt_rd_a.dir : prev_dir;

  // update values: unsolved counts as empty before OR-ing
  assign base      = (tbl_rd == CODE_UNSOLVED) ? 8'h00 : tbl_rd;
  assign wr_dir    = swp ? {4'b0, dir_reg, 2'b0} : {6'b0, dir_reg};
  assign stamp_val = swp ? {4'b0, dir_reg, opp_reg} : {4'b0, opp_reg, dir_reg};

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = tbl_raddr;
    tbl_wdata = CODE_UNSOLVED;
    case (state)
      S_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_addr;
      end
      S_TUSE: begin
        if (pv && op == F_WRITE) begin
          tbl_we    = 1'b1;
          tbl_wdata = unr_reg ? CODE_NONE : (base | wr_dir);
        end else if (pv && op == F_ROUTE && tbl_rd == CODE_UNSOLVED) begin
          tbl_we    = 1'b1;
          tbl_wdata = stamp_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd <= tbl_mem[tbl_raddr];
  end

  assign rt_we = (state == S_ROUTE) && (route_length < RT_LW'(ROUTE_DEPTH));

  always_ff @(posedge clk) begin
    if (rt_we) begin
      route_mem[route_length[RT_AW-1:0]] <= '{node: a_reg, dir: dir_reg};
    end
    rt_rd_a <= route_mem[si];
    rt_rd_b <= route_mem[sj];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      clr_resp     <= 1'b0;
      route_length <= '0;
      out_valid    <= 1'b0;
      si           <= '0;
      sj           <= '0;
    end else begin
      // S_RESP loads or holds the output register itself
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr_addr == PAIR_AW'(PAIR_COUNT - 1)) begin
            state <= clr_resp ? S_RESP : S_IDLE;
          end
          clr_addr <= clr_addr + PAIR_AW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            op       <= func_t'(func);
            a_reg    <= from_node;
            b_reg    <= to_node;
            dir_reg  <= step_dir;
            unr_reg  <= mark_unreachable;
            last_reg <= route_last;
            res_dir  <= 2'd0;
            res_st   <= ST_OK;
            case (func_t'(func))
              F_LOOKUP, F_WRITE: state <= S_SLOT;
              F_ROUTE:           state <= S_ROUTE;
              F_CLEAR: begin
                clr_addr <= '0;
                clr_resp <= 1'b1;
                state    <= S_CLR;
              end
              default:           state <= S_SLOT;
            endcase
          end
        end
        S_SLOT: begin
          tbl_raddr <= PAIR_AW'(slot_full);
          swp       <= (a_reg < b_reg);
          pv        <= pair_ok;
          state     <= S_TRD;
        end
        S_TRD: begin
          state <= S_TUSE;
        end
        S_TUSE: begin
          if (op == F_LOOKUP) begin
            if (!pv || tbl_rd == CODE_NONE) begin
              res_st <= ST_NONE;
            end else if (tbl_rd == CODE_UNSOLVED) begin
              res_st <= ST_UNSOLVED;
            end else begin
              res_dir <= swp ? tbl_rd[3:2] : tbl_rd[1:0];
            end
            state <= S_RESP;
          end else if (op == F_ROUTE) begin
            // next pair: advance j, else next i with j = i + 1
            if (RT_LW'(sj) + RT_LW'(1) < stamp_len) begin
              sj    <= sj + RT_AW'(1);
              state <= S_PRD;
            end else if (RT_LW'(si) + RT_LW'(2) < stamp_len) begin
              si    <= si + RT_AW'(1);
              sj    <= si + RT_AW'(2);
              state <= S_PRD;
            end else begin
              route_length <= '0;
              state        <= S_RESP;
            end
          end else begin
            state <= S_RESP;
          end
        end
        S_ROUTE: begin
          if (last_reg) begin
            if (len_new < RT_LW'(2)) begin
              route_length <= '0;
              state        <= S_RESP;
            end else begin
              route_length <= len_new;
              stamp_len    <= len_new;
              si           <= '0;
              sj           <= RT_AW'(1);
              state        <= S_PRD;
            end
          end else begin
            route_length <= len_new;
            state        <= S_RESP;
          end
        end
        S_PRD: begin
          state <= S_PLD;
        end
        S_PLD: begin
          a_reg    <= rt_rd_a.node;
          b_reg    <= rt_rd_b.node;
          dir_reg  <= rt_rd_a.dir;
          opp_reg  <= jm1_dir + 2'd2;
          prev_dir <= rt_rd_b.dir;
          state    <= S_SLOT;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            dir_out   <= res_dir;
            status    <= res_st;
            clr_resp  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `PNHT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken twice in a row")
  `PNHT_ASSERT_NOW(a_route_len, 1'b1, route_length <= RT_LW'(ROUTE_DEPTH), "route overflow")
  `PNHT_ASSERT_NOW(a_pair_order, state == S_PRD, (sj > si) && (RT_LW'(sj) < stamp_len), "bad pair")
  `PNHT_ASSERT_NEXT(a_resp_done, state == S_RESP && (!out_valid || out_ready), out_valid, "lost result")

endmodule

@@ sim/tb_packed_next_hop_table.sv @@
// Self-checking testbench for packed_next_hop_table: pair lookups, direct writes,
// route stamping, clears and node_count settings, checked against an in-bench table.
// Depends on pnht_pkg and the packed_next_hop_table RTL.
`timescale 1ns / 1ps

module tb_packed_next_hop_table;
  import pnht_pkg::*;

  // one input item and one result item
  typedef struct {
    func_t      fn;
    logic [7:0] src;
    logic [7:0] dst;
    logic [1:0] dir;
    logic       unr;
    logic       last;
  } hop_item_t;

  typedef struct {
    logic [1:0] dir;
    status_t    st;
  } hop_answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       func = '0;
  logic [7:0]       from_node = '0;
  logic [7:0]       to_node = '0;
  logic [1:0]       step_dir = '0;
  logic             mark_unreachable = 1'b0;
  logic             route_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       dir_out;
  logic [1:0]       status;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  packed_next_hop_table uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .from_node        (from_node),
    .to_node          (to_node),
    .step_dir         (step_dir),
    .mark_unreachable (mark_unreachable),
    .route_last       (route_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .dir_out          (dir_out),
    .status           (status)
  );

  // ---------------------------------------------------------------------------
  // Bench copy of the block state
  // ---------------------------------------------------------------------------
  logic [7:0]  pair_tab [PAIR_COUNT];   // lower-triangular, one byte per pair
  logic [7:0]  rt_node  [ROUTE_DEPTH];  // buffered route
  logic [1:0]  rt_dir   [ROUTE_DEPTH];
  int unsigned rt_len = 0;
  int unsigned node_cnt = 0;            // last node_count written

  hop_answer_t pending_answers [$];     // results owed by the block, oldest first
  hop_item_t   stim_q [$];              // items waiting for the driver
  hop_item_t   cur_item;                // item on the input port
  logic [7:0]  recent_nodes [$];        // nodes touched lately, aimed at by lookups

  int unsigned sent_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned clear_cnt = 0;
  int unsigned longest_route = 0;
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;           // receiver hold-off, counted down per cycle

  function automatic void clear_pairs();
    foreach (pair_tab[k]) pair_tab[k] = CODE_UNSOLVED;
  endfunction

  // Slot of an unordered pair; swapped means a < b, i.e. the direction in bits [3:2].
  function automatic bit pair_slot(input int unsigned a, input int unsigned b,
                                   output int unsigned slot, output bit swapped);
    int unsigned n, hi, lo;
    n = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
    slot = 0;
    swapped = 1'b0;
    if (a == b || a >= n || b >= n) return 1'b0;
    if (a < b) begin
      hi = b; lo = a; swapped = 1'b1;
    end else begin
      hi = a; lo = b;
    end
    slot = hi * (hi - 1) / 2 + lo;
    return slot < PAIR_COUNT;
  endfunction

  // Step 0..3, or CODE_UNSOLVED / CODE_NONE
  function automatic logic [7:0] pair_read(input int unsigned a, input int unsigned b);
    int unsigned slot;
    bit          sw;
    logic [7:0]  v;
    if (!pair_slot(a, b, slot, sw)) return CODE_NONE;
    v = pair_tab[slot];
    if (v == CODE_NONE || v == CODE_UNSOLVED) return v;
    return sw ? {6'd0, v[3:2]} : {6'd0, v[1:0]};
  endfunction

  function automatic void pair_write(input int unsigned a, input int unsigned b,
                                     input logic [1:0] d, input logic unr);
    int unsigned slot;
    bit          sw;
    logic [7:0]  v;
    if (!pair_slot(a, b, slot, sw)) return;
    if (unr) begin
      pair_tab[slot] = CODE_NONE;
      return;
    end
    v = pair_tab[slot];
    if (v == CODE_UNSOLVED) v = 8'h00;
    // OR into 0xff leaves it unreachable
    pair_tab[slot] = sw ? (v | {4'd0, d, 2'd0}) : (v | {6'd0, d});
  endfunction

  // Fill every still-unsolved pair along the buffered route, both ways.
  function automatic void stamp_route();
    int unsigned i, j;
    logic [1:0]  back;
    for (i = 0; i + 1 < rt_len; i++) begin
      for (j = i + 1; j < rt_len; j++) begin
        if (pair_read(rt_node[i], rt_node[j]) == CODE_UNSOLVED) begin
          back = rt_dir[j-1] + 2'd2;
          pair_write(rt_node[i], rt_node[j], rt_dir[i], 1'b0);
          pair_write(rt_node[j], rt_node[i], back, 1'b0);
        end
      end
    end
    rt_len = 0;
  endfunction

  // Apply one accepted item to the bench state and queue its answer.
  function automatic void compute_answer(input hop_item_t it);
    hop_answer_t ans;
    logic [7:0]  r;
    ans.dir = 2'd0;
    ans.st  = ST_OK;
    case (it.fn)
      F_LOOKUP: begin
        r = pair_read(it.src, it.dst);
        if (r == CODE_UNSOLVED)  ans.st = ST_UNSOLVED;
        else if (r == CODE_NONE) ans.st = ST_NONE;
        else                     ans.dir = r[1:0];
      end
      F_WRITE: pair_write(it.src, it.dst, it.dir, it.unr);
      F_ROUTE: begin
        // full buffer drops the step; a last step still stamps
        if (rt_len < ROUTE_DEPTH) begin
          rt_node[rt_len] = it.src;
          rt_dir[rt_len]  = it.dir;
          rt_len++;
        end
        if (it.last) begin
          if (rt_len > longest_route) longest_route = rt_len;
          stamp_route();
        end
      end
      default: begin
        // clear leaves the route buffer alone
        clear_pairs();
        clear_cnt++;
      end
    endcase
    pending_answers.push_back(ans);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one NBA per signal per edge, valid held until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      accepted_cnt++;
      compute_answer(cur_item);
    end
    if (!in_valid || in_ready) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = stim_q.pop_front();
        in_valid         <= 1'b1;
        func             <= cur_item.fn;
        from_node        <= cur_item.src;
        to_node          <= cur_item.dst;
        step_dir         <= cur_item.dir;
        mark_unreachable <= cur_item.unr;
        route_last       <= cur_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: compare against the oldest answer, then pick next out_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    hop_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        err_count++;
        $display("%0t ns: result with nothing owed, dir_out %0d status %0d",
                 $time, dir_out, status);
      end else begin
        want = pending_answers.pop_front();
        checked_cnt++;
        if (dir_out !== want.dir) begin
          err_count++;
          $display("%0t ns: dir_out expected %0d actual %0d", $time, want.dir, dir_out);
        end
        if (status !== want.st) begin
          err_count++;
          $display("%0t ns: status expected %0d actual %0d", $time, want.st, status);
        end
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------
  function automatic hop_item_t mk(input func_t fn, input logic [7:0] a, input logic [7:0] b,
                                   input logic [1:0] d, input logic u, input logic l);
    hop_item_t it;
    it.fn = fn; it.src = a; it.dst = b; it.dir = d; it.unr = u; it.last = l;
    return it;
  endfunction

  // Mostly a node in use, sometimes any node (out of range when node_count is small)
  function automatic logic [7:0] rand_node();
    int unsigned n;
    n = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
    if (n == 0 || $urandom_range(99) < 15) return 8'($urandom_range(255));
    return 8'($urandom_range(n - 1));
  endfunction

  task automatic send_item(input hop_item_t it);
    while (stim_q.size() >= 2) @(posedge clk);
    stim_q.push_back(it);
    sent_cnt++;
    if (it.fn == F_WRITE || it.fn == F_ROUTE) begin
      recent_nodes.push_back(it.src);
      if (it.fn == F_WRITE) recent_nodes.push_back(it.dst);
      while (recent_nodes.size() > 8) void'(recent_nodes.pop_front());
    end
  endtask

  // All items taken, all answers in, block back to taking items
  task automatic wait_idle();
    do @(posedge clk); while (accepted_cnt != sent_cnt || pending_answers.size() != 0);
    repeat (8) @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic set_node_count(input int unsigned v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v[CFG_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    node_cnt = v & 9'h1ff;
  endtask

  task automatic set_pace(input int unsigned snd, input int unsigned rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // Random mix: lookups, writes, well-formed routes, stray route steps, rare clears
  task automatic run_random(input int unsigned count, input int unsigned clear_budget);
    int unsigned done_cnt, r, len, k;
    logic [7:0]  a, b;
    done_cnt = 0;
    while (done_cnt < count) begin
      r = $urandom_range(99);
      if (r < 35) begin
        if (recent_nodes.size() >= 2 && $urandom_range(1) == 1) begin
          a = recent_nodes[$urandom_range(recent_nodes.size() - 1)];
          b = recent_nodes[$urandom_range(recent_nodes.size() - 1)];
        end else begin
          a = rand_node();
          b = rand_node();
        end
        send_item(mk(F_LOOKUP, a, b, 2'($urandom_range(3)), 1'($urandom_range(1)),
                     1'($urandom_range(1))));
        done_cnt++;
      end else if (r < 55) begin
        send_item(mk(F_WRITE, rand_node(), rand_node(), 2'($urandom_range(3)),
                     ($urandom_range(9) == 0), 1'($urandom_range(1))));
        done_cnt++;
      end else if (r < 85) begin
        len = $urandom_range(6, 2);
        for (k = 0; k < len; k++)
          send_item(mk(F_ROUTE, rand_node(), 8'($urandom_range(255)),
                       2'($urandom_range(3)), 1'($urandom_range(1)), (k == len - 1)));
        done_cnt += len;
      end else if (r < 99 || clear_budget == 0 || $urandom_range(3) != 0) begin
        send_item(mk(F_ROUTE, rand_node(), 8'($urandom_range(255)), 2'($urandom_range(3)),
                     1'($urandom_range(1)), 1'($urandom_range(1))));
        done_cnt++;
      end else begin
        send_item(mk(F_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1))));
        clear_budget--;
        done_cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lookup codes, both direction fields of a pair, unreachable marking and same-node pairs
  task automatic test_lookup_write();
    set_node_count(256);
    send_item(mk(F_LOOKUP, 8'd0,   8'd0,   2'd0, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd255, 8'd254, 2'd0, 1'b0, 1'b0));
    send_item(mk(F_WRITE,  8'd255, 8'd254, 2'd3, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd255, 8'd254, 2'd0, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd254, 8'd255, 2'd0, 1'b0, 1'b0));
    send_item(mk(F_WRITE,  8'd254, 8'd255, 2'd2, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd254, 8'd255, 2'd0, 1'b0, 1'b0));
    send_item(mk(F_WRITE,  8'd0,   8'd255, 2'd0, 1'b1, 1'b0));
    send_item(mk(F_LOOKUP, 8'd255, 8'd0,   2'd0, 1'b0, 1'b0));
    // a step ORed over unreachable stays unreachable
    send_item(mk(F_WRITE,  8'd255, 8'd0,   2'd1, 1'b0, 1'b1));
    send_item(mk(F_LOOKUP, 8'd0,   8'd255, 2'd3, 1'b1, 1'b1));
    send_item(mk(F_WRITE,  8'd7,   8'd7,   2'd3, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd7,   8'd7,   2'd0, 1'b0, 1'b0));
  endtask

  // Short route stamps both ways; a one-step route stamps nothing
  task automatic test_route_stamp();
    send_item(mk(F_ROUTE,  8'd3, 8'd0, 2'd1, 1'b0, 1'b0));
    send_item(mk(F_ROUTE,  8'd7, 8'd0, 2'd2, 1'b0, 1'b0));
    send_item(mk(F_ROUTE,  8'd9, 8'd0, 2'd0, 1'b0, 1'b1));
    send_item(mk(F_LOOKUP, 8'd3, 8'd9, 2'd0, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd9, 8'd3, 2'd0, 1'b0, 1'b0));
    send_item(mk(F_ROUTE,  8'd5, 8'd0, 2'd3, 1'b0, 1'b1));
    send_item(mk(F_LOOKUP, 8'd5, 8'd3, 2'd0, 1'b0, 1'b0));
  endtask

  // Out-of-range nodes and a full clear
  task automatic test_range_and_clear();
    set_node_count(12);
    send_item(mk(F_LOOKUP, 8'd200, 8'd3,   2'd0, 1'b0, 1'b0));
    send_item(mk(F_WRITE,  8'd3,   8'd200, 2'd1, 1'b0, 1'b0));
    send_item(mk(F_WRITE,  8'd11,  8'd10,  2'd2, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd11,  8'd10,  2'd0, 1'b0, 1'b0));
    send_item(mk(F_CLEAR,  8'd0,   8'd0,   2'd0, 1'b0, 1'b0));
    send_item(mk(F_LOOKUP, 8'd11,  8'd10,  2'd0, 1'b0, 1'b0));
  endtask

  // node_count of zero, all ones (clamped), one and two
  task automatic test_node_count_extremes();
    set_node_count(0);
    run_random(30, 0);
    set_node_count(511);
    run_random(30, 0);
    set_node_count(1);
    run_random(30, 0);
    set_node_count(2);
    run_random(30, 0);
  endtask

  // Overfill the route buffer, then stamp it whole
  task automatic test_full_route();
    logic [7:0] hops [$];
    int unsigned k;
    set_node_count(256);
    for (k = 0; k < 300; k++) begin
      hops.push_back(8'($urandom_range(255)));
      send_item(mk(F_ROUTE, hops[k], 8'($urandom_range(255)), 2'($urandom_range(3)),
                   1'b0, 1'b0));
    end
    send_item(mk(F_ROUTE, 8'($urandom_range(255)), 8'd0, 2'($urandom_range(3)),
                 1'b0, 1'b1));
    for (k = 0; k < 20; k++)
      send_item(mk(F_LOOKUP, hops[$urandom_range(255)], hops[$urandom_range(255)],
                   2'd0, 1'b0, 1'b0));
  endtask

  // Receiver holds off while items keep coming: block fills and stalls its input
  task automatic test_backpressure();
    wait_idle();
    hold_left <= 400;
    run_random(40, 0);
  endtask

  task automatic test_random_phases();
    set_pace(38, 45);
    set_node_count(12);
    run_random(400, 1);
    set_pace(45, 38);
    set_node_count(48);
    run_random(400, 1);
    set_pace(0, 0);
    set_node_count(256);
    run_random(400, 1);
  endtask

  initial begin
    clear_pairs();
    set_pace(38, 45);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    while (in_ready !== 1'b1) @(posedge clk);
    test_lookup_write();
    test_route_stamp();
    test_range_and_clear();
    test_node_count_extremes();
    test_full_route();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (40) @(posedge clk);
    $display("run covered %0d items and %0d checked results over node counts 0 to 511,",
             accepted_cnt, checked_cnt);
    $display("with %0d table clears and routes up to %0d buffered steps", clear_cnt,
             longest_route);
    if (err_count == 0)
      $display("tb_packed_next_hop_table: clean");
    else
      $display("tb_packed_next_hop_table: errors");
    $finish;
  end

  // Watchdog: far above the slowest legal run (clearing passes and full-route stamp)
  initial begin
    #60_000_000;
    $display("timeout with %0d answers outstanding", pending_answers.size());
    $display("tb_packed_next_hop_table: errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pnht_pkg.sv
rtl/packed_next_hop_table.sv
sim/tb_packed_next_hop_table.sv
